/* rtl/sibmd_pkg.sv */
`timescale 1ns / 1ps

package sibmd_pkg;

   localparam int IDX_W           = 6;
   localparam int KEY_W           = 24;
   localparam int MAX_ENTRIES_DEF = 64;
   localparam int DATA_W          = 32;

   // key in the upper bits, so a packed compare orders by key, then by index
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [IDX_W-1:0] idx;
   } entry_type;

   typedef struct packed {
      logic ins_en;
      logic shift_en;
   } ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

/* rtl/sibmd_cell.sv */
`timescale 1ns / 1ps

module sibmd_cell (
   input  logic                 clock,
   input  sibmd_pkg::ctrl_type  ctrl,
   input  logic                 valid,
   input  sibmd_pkg::entry_type new_entry,
   input  sibmd_pkg::entry_type prev_entry,
   input  logic                 prev_valid,
   input  logic                 prev_ins,
   input  sibmd_pkg::entry_type next_entry,
   output sibmd_pkg::entry_type entry,
   output logic                 ins
);

   sibmd_pkg::entry_type data_ff;
   sibmd_pkg::entry_type data_in;

   always_comb begin
      ins     = !valid || (new_entry > data_ff);
      data_in = data_ff;
      if (ctrl.shift_en) begin
         data_in = next_entry;
      end else if (ctrl.ins_en) begin
         if (prev_ins && prev_valid) begin
            data_in = prev_entry;
         end else if (!prev_ins && ins) begin
            data_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry = data_ff;

endmodule

/* rtl/sort_indices_by_momentum_desc.sv */
`timescale 1ns / 1ps

// chan  dir  payload
// req_  in   tdata: particle_index, momentum_key; tlast: last_entry
// rsp_  out  tdata: sorted_index, sorted_momentum; tlast: last_result; tuser: overflow
//
// loading takes one request per cycle, each inserted by the registered cell chain;
// a request that arrives while the chain is full is dropped and sets the overflow flag;
// on the request with tlast the chain drains from cell 0, one result per cycle while
// rsp_tready is high, and req_tready is low until the cycle after the last result
// rsp_tready low holds the chain and the current result in place
// synchronous reset clears the fill count, overflow flag and state; cell contents are not reset

module sort_indices_by_momentum_desc #(
   parameter int MAX_ENTRIES = sibmd_pkg::MAX_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sibmd_pkg::DATA_W-1:0] req_tdata,   // [5:0] particle_index, [29:6] momentum_key
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sibmd_pkg::DATA_W-1:0] rsp_tdata,   // [5:0] sorted_index, [29:6] sorted_momentum
   output logic                         rsp_tlast,
   output logic                         rsp_tuser    // [0] overflow
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int ENT_W = sibmd_pkg::KEY_W + sibmd_pkg::IDX_W;

   sibmd_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 dropped_ff, dropped_in;

   sibmd_pkg::ctrl_type  ctrl;
   sibmd_pkg::entry_type new_entry;
   sibmd_pkg::entry_type entries [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] ins;
   logic [MAX_ENTRIES-1:0] valid;

   logic req_fire, rsp_fire, full;

   assign req_tready = (state_ff == sibmd_pkg::ST_LOAD);
   assign rsp_tvalid = (state_ff == sibmd_pkg::ST_DRAIN);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign full       = (count_ff == CNT_W'(MAX_ENTRIES));

   assign new_entry.key = req_tdata[ENT_W-1:sibmd_pkg::IDX_W];
   assign new_entry.idx = req_tdata[sibmd_pkg::IDX_W-1:0];

   assign ctrl.ins_en   = req_fire && !full;
   assign ctrl.shift_en = rsp_fire;

   genvar i;
   generate
      for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
         sibmd_pkg::entry_type prev_e;
         sibmd_pkg::entry_type next_e;
         logic                 prev_v;
         logic                 prev_i;

         assign valid[i] = (count_ff > CNT_W'(i));

         if (i == 0) begin : g_first
            assign prev_e = new_entry;
            assign prev_v = 1'b0;
            assign prev_i = 1'b0;
         end else begin : g_mid
            assign prev_e = entries[i-1];
            assign prev_v = valid[i-1];
            assign prev_i = ins[i-1];
         end

         if (i == MAX_ENTRIES - 1) begin : g_end
            assign next_e = new_entry;
         end else begin : g_nxt
            assign next_e = entries[i+1];
         end

         sibmd_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .valid      (valid[i]),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .prev_ins   (prev_i),
            .next_entry (next_e),
            .entry      (entries[i]),
            .ins        (ins[i])
         );
      end
   endgenerate

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         sibmd_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = sibmd_pkg::ST_DRAIN;
               end
            end
         end
         sibmd_pkg::ST_DRAIN: begin
            if (rsp_fire) begin
               count_in = count_ff - CNT_W'(1);
               if (rsp_tlast) begin
                  dropped_in = 1'b0;
                  state_in   = sibmd_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = sibmd_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sibmd_pkg::ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign rsp_tdata = {{(sibmd_pkg::DATA_W - ENT_W){1'b0}}, entries[0].key, entries[0].idx};
   assign rsp_tlast = (count_ff == CNT_W'(1));
   assign rsp_tuser = dropped_ff;

endmodule
